// ===== src/binary_to_ascii_digits_core_assert.svh =====
// Assertion macros for the digit formatter.
// B2A_ASSERT_NOW checks an implication in the same cycle.
// B2A_ASSERT_NEXT checks an implication in the next cycle.
// Both are sampled on clk and are disabled while rst_n is low.
`ifndef BINARY_TO_ASCII_DIGITS_CORE_ASSERT_SVH
`define BINARY_TO_ASCII_DIGITS_CORE_ASSERT_SVH
`ifndef ASSERT_OFF
`define B2A_ASSERT_NOW(lbl, cond_a, cond_b) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond_a) |-> (cond_b)) \
        else $error("assertion failed");
`define B2A_ASSERT_NEXT(lbl, cond_a, cond_b) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond_a) |=> (cond_b)) \
        else $error("assertion failed");
`else
`define B2A_ASSERT_NOW(lbl, cond_a, cond_b)
`define B2A_ASSERT_NEXT(lbl, cond_a, cond_b)
`endif
`endif

// ===== src/b2a_pkg.sv =====
`timescale 1ns / 1ps

package b2a_pkg;

    // Default digit count of the 32-bit decimal format.
    localparam int B2A_MAX_DIGITS = 10;

    // Format kinds.
    localparam logic [2:0] KIND_DEC3  = 3'd0;
    localparam logic [2:0] KIND_DEC5  = 3'd1;
    localparam logic [2:0] KIND_DEC32 = 3'd2;
    localparam logic [2:0] KIND_HEX2  = 3'd3;
    localparam logic [2:0] KIND_HEX4  = 3'd4;

    localparam logic [6:0] ASCII_ZERO = 7'h30;
    localparam logic [6:0] ASCII_A    = 7'h61;

    typedef struct packed {
        logic [2:0]  kind;
        logic [31:0] value;
    } in_item_t;

    typedef struct packed {
        logic [6:0] char_code;
        logic       last;
    } out_item_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CONV,
        ST_EMIT
    } b2a_state_t;

    // Map one digit value to its ASCII character.
    function automatic logic [6:0] digit_char(input logic [3:0] d);
        if (d < 4'd10)
        begin
            digit_char = ASCII_ZERO + {3'd0, d};
        end
        else
        begin
            digit_char = ASCII_A + {3'd0, d - 4'd10};
        end
    endfunction

endpackage

// ===== src/binary_to_ascii_digits_core.sv =====
`timescale 1ns / 1ps
// Binary to ASCII digit formatter.
// Input channel in_valid/in_stall/in_item carries a format kind and a 32-bit
// value. Output channel out_valid/out_stall/out_item carries one ASCII
// character per transfer, most significant digit first, with last set on the
// final character of the number. Unknown kinds are taken and give nothing.
// Decimal kinds run a double dabble conversion that shifts one value bit per
// cycle through a BCD register for the 8-, 16- or 32-bit formats. Hex kinds
// skip that phase. Characters then leave one per cycle, while the output is
// not stalled, from a shifting digit register: 3, 5, MAX_DIGITS, 2 or 4 of
// them. A new number is taken only once the last character of the previous
// one is in the output register. in_stall is high while a number is in work.
// A stalled output keeps its character in the output register and holds the
// digit register until the transfer happens.
// Reset clears the controller and the output valid; no clearing pass.
module binary_to_ascii_digits_core
    import b2a_pkg::*;
#(
    parameter int MAX_DIGITS = B2A_MAX_DIGITS
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_stall,
    input  in_item_t  in_item,
    output logic      out_valid,
    input  logic      out_stall,
    output out_item_t out_item
);

    localparam int BW = MAX_DIGITS * 4;

    b2a_state_t      state_reg, state_next;
    logic [31:0]     sh_reg, sh_next;
    logic [BW-1:0]   bcd_reg, bcd_next;
    logic [5:0]      cnt_reg, cnt_next;
    logic [2:0]      kind_reg, kind_next;
    logic            out_valid_reg, out_valid_next;
    out_item_t       out_item_reg, out_item_next;

    logic            in_take;
    logic            kind_ok;
    logic            out_free;
    logic [BW-1:0]   dabble;
    logic [3:0]      top_digit;
    logic [5:0]      dec_digits;

    assign in_stall  = (state_reg != ST_IDLE);
    assign in_take   = in_valid && !in_stall;
    assign kind_ok   = (in_item.kind <= KIND_HEX4);
    assign out_free  = !out_valid_reg || !out_stall;
    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

    // One double dabble step: add three to each digit above four, shift in a bit.
    always_comb
    begin
        logic [BW-1:0] adj;
        adj = bcd_reg;
        for (int i = 0; i < MAX_DIGITS; i++)
        begin
            if (bcd_reg[i*4 +: 4] >= 4'd5)
            begin
                adj[i*4 +: 4] = bcd_reg[i*4 +: 4] + 4'd3;
            end
        end
        dabble = {adj[BW-2:0], sh_reg[31]};
    end

    // Digit count of the decimal format held in kind_reg.
    always_comb
    begin
        case (kind_reg)
            KIND_DEC3:  dec_digits = 6'd3;
            KIND_DEC5:  dec_digits = 6'd5;
            default:    dec_digits = 6'(MAX_DIGITS);
        endcase
    end

    // Most significant remaining digit for the current format.
    always_comb
    begin
        case (kind_reg)
            KIND_DEC3:  top_digit = bcd_reg[11:8];
            KIND_DEC5:  top_digit = bcd_reg[19:16];
            KIND_DEC32: top_digit = bcd_reg[BW-1 -: 4];
            KIND_HEX2:  top_digit = bcd_reg[7:4];
            KIND_HEX4:  top_digit = bcd_reg[15:12];
            default:    top_digit = bcd_reg[3:0];
        endcase
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_take && kind_ok)
                begin
                    if (in_item.kind == KIND_HEX2 || in_item.kind == KIND_HEX4)
                    begin
                        state_next = ST_EMIT;
                    end
                    else
                    begin
                        state_next = ST_CONV;
                    end
                end
            end
            ST_CONV:
            begin
                if (cnt_reg == 6'd1)
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (out_free && cnt_reg == 6'd1)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Datapath and output register control.
    always_comb
    begin
        sh_next        = sh_reg;
        bcd_next       = bcd_reg;
        cnt_next       = cnt_reg;
        kind_next      = kind_reg;
        out_item_next  = out_item_reg;
        out_valid_next = out_valid_reg && out_stall;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_take)
                begin
                    kind_next = in_item.kind;
                    bcd_next  = '0;
                    case (in_item.kind)
                        KIND_DEC3:
                        begin
                            sh_next  = {in_item.value[7:0], 24'd0};
                            cnt_next = 6'd8;
                        end
                        KIND_DEC5:
                        begin
                            sh_next  = {in_item.value[15:0], 16'd0};
                            cnt_next = 6'd16;
                        end
                        KIND_DEC32:
                        begin
                            sh_next  = in_item.value;
                            cnt_next = 6'd32;
                        end
                        KIND_HEX2:
                        begin
                            bcd_next = BW'(in_item.value[7:0]);
                            cnt_next = 6'd2;
                        end
                        KIND_HEX4:
                        begin
                            bcd_next = BW'(in_item.value[15:0]);
                            cnt_next = 6'd4;
                        end
                        default:
                        begin
                            cnt_next = cnt_reg;
                        end
                    endcase
                end
            end
            ST_CONV:
            begin
                bcd_next = dabble;
                sh_next  = {sh_reg[30:0], 1'b0};
                if (cnt_reg == 6'd1)
                begin
                    cnt_next = dec_digits;
                end
                else
                begin
                    cnt_next = cnt_reg - 6'd1;
                end
            end
            ST_EMIT:
            begin
                if (out_free)
                begin
                    out_valid_next          = 1'b1;
                    out_item_next.char_code = digit_char(top_digit);
                    out_item_next.last      = (cnt_reg == 6'd1);
                    bcd_next                = {bcd_reg[BW-5:0], 4'd0};
                    cnt_next                = cnt_reg - 6'd1;
                end
            end
            default:
            begin
                cnt_next = cnt_reg;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        sh_reg       <= sh_next;
        bcd_reg      <= bcd_next;
        kind_reg     <= kind_next;
        out_item_reg <= out_item_next;
    end

`include "binary_to_ascii_digits_core_assert.svh"

    // A known kind always starts work on the next cycle.
    `B2A_ASSERT_NEXT(a_known_kind_starts, in_take && kind_ok, state_reg != ST_IDLE)
    // Work in progress always has a nonzero count.
    `B2A_ASSERT_NOW(a_busy_count, state_reg != ST_IDLE, cnt_reg != 6'd0)
    // Leaving emission means the last character was just loaded.
    `B2A_ASSERT_NEXT(a_last_on_exit, state_reg == ST_EMIT && state_next == ST_IDLE,
        out_valid_reg && out_item_reg.last)

endmodule
